/* sv/shv_pkg.sv */
`default_nettype none
// ----------------------------------------------------------------------------
// shv_pkg
// types and constants shared by the shard set validator modules
// ----------------------------------------------------------------------------
package shv_pkg;

	localparam int ADDR_W = 5;
	localparam int DATA_W = 64;

	localparam logic [10:0] HDRS_TAKEN_MAX = 11'd2047;

	localparam logic [63:0] RST_SET_ID      = 64'd0;
	localparam logic [7:0]  RST_VERSION     = 8'd2;
	localparam logic [10:0] RST_MAX_HEADERS = 11'd64;

	localparam logic STATUS_OK  = 1'b0;
	localparam logic STATUS_BAD = 1'b1;

	typedef enum logic [1:0] {
		REG_SET_ID      = 2'd0,
		REG_VERSION     = 2'd1,
		REG_MAX_HEADERS = 2'd2
	} reg_idx_t;

	typedef struct packed {
		logic [7:0]  hdr_version;
		logic [7:0]  hdr_shard_count;
		logic [7:0]  hdr_shard_index;
		logic [63:0] hdr_set_id;
		logic        set_end;
	} hdr_word_t;

	typedef struct packed {
		logic       status;
		logic [7:0] total_shards;
	} res_word_t;

	typedef struct packed {
		logic [63:0] match_set_id;
		logic [7:0]  expected_version;
		logic [10:0] max_headers;
	} cfg_t;

endpackage
`default_nettype wire

/* sv/shv_cfg_regs.sv */
`default_nettype none
// ----------------------------------------------------------------------------
// shv_cfg_regs
// apb register file holding set identifier, version and header limit
// ----------------------------------------------------------------------------
module shv_cfg_regs
	import shv_pkg::*;
(
	input  wire logic              clk,
	input  wire logic              arst_n,
	input  wire logic              psel,
	input  wire logic              penable,
	input  wire logic              pwrite,
	input  wire logic [ADDR_W-1:0] paddr,
	input  wire logic [DATA_W-1:0] pwdata,
	output logic      [DATA_W-1:0] prdata,
	output logic                   pready,
	output cfg_t                   cfg
);

	cfg_t cfg_q;
	logic wr_en;
	logic [1:0] reg_sel;

	assign pready  = 1'b1;
	assign wr_en   = psel && penable && pwrite;
	assign reg_sel = paddr[4:3];
	assign cfg     = cfg_q;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			cfg_q.match_set_id     <= RST_SET_ID;
			cfg_q.expected_version <= RST_VERSION;
			cfg_q.max_headers      <= RST_MAX_HEADERS;
		end else if (wr_en) begin
			case (reg_sel)
				REG_SET_ID:      cfg_q.match_set_id     <= pwdata;
				REG_VERSION:     cfg_q.expected_version <= pwdata[7:0];
				REG_MAX_HEADERS: cfg_q.max_headers      <= pwdata[10:0];
				default: ;
			endcase
		end
	end

	always_comb begin
		case (reg_sel)
			REG_SET_ID:      prdata = cfg_q.match_set_id;
			REG_VERSION:     prdata = {56'd0, cfg_q.expected_version};
			REG_MAX_HEADERS: prdata = {53'd0, cfg_q.max_headers};
			default:         prdata = '0;
		endcase
	end

endmodule
`default_nettype wire

/* sv/shv_set_tracker.sv */
`default_nettype none
// ----------------------------------------------------------------------------
// shv_set_tracker
// per-header checks and set state, one header word per step
// ----------------------------------------------------------------------------
module shv_set_tracker
	import shv_pkg::*;
#(
	parameter int MAX_SHARDS  = 32,
	parameter int SET_ID_BITS = 64
) (
	input  wire logic      clk,
	input  wire logic      arst_n,
	input  wire cfg_t      cfg,
	input  wire hdr_word_t item,
	input  wire logic      step,
	output res_word_t      result
);

	localparam logic [7:0] MAX_CNT = 8'(MAX_SHARDS);

	logic [MAX_SHARDS-1:0] seen_q, seen_n, idx_hot;
	logic [7:0]            agreed_q, agreed_n;
	logic [10:0]           taken_q, taken_n;
	logic                  zero_q, zero_n;
	logic                  err_q, err_n;
	logic                  pass, ok;

	always_comb begin
		for (int i = 0; i < MAX_SHARDS; i++) begin
			idx_hot[i] = (item.hdr_shard_index == 8'(i));
		end
	end

	assign pass = (item.hdr_version == cfg.expected_version)
		&& (item.hdr_shard_count != 8'd0)
		&& (item.hdr_shard_count <= MAX_CNT)
		&& (item.hdr_shard_index < item.hdr_shard_count)
		&& (item.hdr_set_id[SET_ID_BITS-1:0] == cfg.match_set_id[SET_ID_BITS-1:0])
		&& ((taken_q == 11'd0) || (item.hdr_shard_count == agreed_q))
		&& !(|(seen_q & idx_hot));

	always_comb begin
		seen_n   = seen_q;
		agreed_n = agreed_q;
		zero_n   = zero_q;
		err_n    = err_q;
		if (!err_q) begin
			if (pass) begin
				if (taken_q == 11'd0) begin
					agreed_n = item.hdr_shard_count;
				end
				seen_n = seen_q | idx_hot;
				if (item.hdr_shard_index == 8'd0) begin
					zero_n = 1'b1;
				end
			end else begin
				err_n = 1'b1;
			end
		end
		taken_n = (taken_q == HDRS_TAKEN_MAX) ? taken_q : taken_q + 11'd1;
		if (taken_n > cfg.max_headers) begin
			err_n = 1'b1;
		end
	end

	assign ok = !err_n && zero_n && (taken_n == {3'd0, agreed_n});
	assign result.status       = ok ? STATUS_OK : STATUS_BAD;
	assign result.total_shards = ok ? agreed_n : 8'd0;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			seen_q   <= '0;
			agreed_q <= 8'd0;
			taken_q  <= 11'd0;
			zero_q   <= 1'b0;
			err_q    <= 1'b0;
		end else if (step) begin
			if (item.set_end) begin
				seen_q   <= '0;
				agreed_q <= 8'd0;
				taken_q  <= 11'd0;
				zero_q   <= 1'b0;
				err_q    <= 1'b0;
			end else begin
				seen_q   <= seen_n;
				agreed_q <= agreed_n;
				taken_q  <= taken_n;
				zero_q   <= zero_n;
				err_q    <= err_n;
			end
		end
	end

endmodule
`default_nettype wire

/* sv/shard_set_validator_core.sv */
`default_nettype none
// ----------------------------------------------------------------------------
// shard_set_validator_core
// validates sets of shard headers and reports one status word per set
// ----------------------------------------------------------------------------
// One header word is taken per clock. A header goes into an input register,
// is checked against the set state in the following cycle, and on the last
// header of a set the status word is registered into the output register,
// which drives res_valid, once that register is free.
// Rate is one header per cycle, set by the update of the seen map and set
// counters on each step; the input stalls only when a finished status word
// is still held.
module shard_set_validator_core
	import shv_pkg::*;
#(
	parameter int MAX_SHARDS  = 32,
	parameter int SET_ID_BITS = 64
) (
	input  wire logic              clk,
	input  wire logic              arst_n,
	input  wire logic              psel,
	input  wire logic              penable,
	input  wire logic              pwrite,
	input  wire logic [ADDR_W-1:0] paddr,
	input  wire logic [DATA_W-1:0] pwdata,
	output logic      [DATA_W-1:0] prdata,
	output logic                   pready,
	input  wire logic              hdr_valid,
	output logic                   hdr_stall,
	input  wire hdr_word_t         hdr,
	output logic                   res_valid,
	input  wire logic              res_stall,
	output res_word_t              res
);

	cfg_t      cfg;
	hdr_word_t hdr_s1;
	logic      valid_s1;
	res_word_t result;
	res_word_t res_q;
	logic      res_valid_q;
	logic      out_free, step;

	shv_cfg_regs u_regs (
		.clk     (clk),
		.arst_n  (arst_n),
		.psel    (psel),
		.penable (penable),
		.pwrite  (pwrite),
		.paddr   (paddr),
		.pwdata  (pwdata),
		.prdata  (prdata),
		.pready  (pready),
		.cfg     (cfg)
	);

	shv_set_tracker #(
		.MAX_SHARDS  (MAX_SHARDS),
		.SET_ID_BITS (SET_ID_BITS)
	) u_tracker (
		.clk    (clk),
		.arst_n (arst_n),
		.cfg    (cfg),
		.item   (hdr_s1),
		.step   (step),
		.result (result)
	);

	assign out_free  = !res_valid_q || !res_stall;
	assign step      = valid_s1 && (!hdr_s1.set_end || out_free);
	assign hdr_stall = valid_s1 && !step;
	assign res_valid = res_valid_q;
	assign res       = res_q;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_s1    <= 1'b0;
			res_valid_q <= 1'b0;
		end else begin
			if (!hdr_stall) begin
				valid_s1 <= hdr_valid;
			end
			if (step && hdr_s1.set_end) begin
				res_valid_q <= 1'b1;
			end else if (!res_stall) begin
				res_valid_q <= 1'b0;
			end
		end
	end

	always_ff @(posedge clk) begin
		if (hdr_valid && !hdr_stall) begin
			hdr_s1 <= hdr;
		end
		if (step && hdr_s1.set_end) begin
			res_q <= result;
		end
	end

endmodule
`default_nettype wire

/* sv/shv_checker.sv */
`default_nettype none
// ----------------------------------------------------------------------------
// shv_checker
// port-level checks on the shard set validator, bound to the top level
// ----------------------------------------------------------------------------
module shv_checker
	import shv_pkg::*;
(
	input wire logic      clk,
	input wire logic      arst_n,
	input wire logic      hdr_stall,
	input wire logic      res_valid,
	input wire logic      res_stall,
	input wire res_word_t res
);

	// a held status word keeps its value
	a_res_hold: assert property (@(posedge clk) disable iff (!arst_n)
		res_valid && res_stall |=> res_valid && $stable(res))
		else $error("status word changed while stalled");

	a_ok_count: assert property (@(posedge clk) disable iff (!arst_n)
		res_valid && (res.status == STATUS_OK) |-> res.total_shards != 8'd0)
		else $error("ok status with zero shard count");

	a_bad_zero: assert property (@(posedge clk) disable iff (!arst_n)
		res_valid && (res.status == STATUS_BAD) |-> res.total_shards == 8'd0)
		else $error("bad status with non-zero shard count");

	// input back-pressure only comes from a held status word
	a_stall_src: assert property (@(posedge clk) disable iff (!arst_n)
		hdr_stall |-> res_valid && res_stall)
		else $error("header stalled without held status word");

endmodule

bind shard_set_validator_core shv_checker u_shv_checker (
	.clk       (clk),
	.arst_n    (arst_n),
	.hdr_stall (hdr_stall),
	.res_valid (res_valid),
	.res_stall (res_stall),
	.res       (res)
);
`default_nettype wire

/* sim/tb.sv */
`default_nettype none
// ----------------------------------------------------------------------------
// tb
// self-checking bench for shard_set_validator_core: header words are sent as
// directed cases and then as random sets (mostly well-formed, some broken,
// some noise) under several register settings. A scoreboard class predicts
// one status word per set and checks each status word as it is taken.
// ----------------------------------------------------------------------------
module tb;
	import shv_pkg::*;

	localparam int MAX_SHARDS  = 32;
	localparam int N_PHASES    = 12;
	localparam int PHASE_WORDS = 90;
	localparam int CYCLE_LIMIT = 600000;
	localparam int HDR_W       = $bits(hdr_word_t);

	typedef enum {
		SK_GOOD, SK_VERSION, SK_COUNT, SK_INDEX, SK_SET_ID,
		SK_COUNT_CHANGE, SK_DUP, SK_MISSING, SK_NOISE
	} set_kind_e;

	class shard_set_scoreboard;
		logic [63:0] set_id_cfg;
		logic [7:0]  version_cfg;
		logic [10:0] max_hdr_cfg;
		bit [31:0]   seen;
		logic [7:0]  agreed;
		logic [10:0] taken;
		bit          zero_seen;
		bit          latched;
		res_word_t   pending[$];
		int          errors;
		int          hdrs;
		int          sets_ok;
		int          sets_bad;

		function new();
			set_id_cfg  = RST_SET_ID;
			version_cfg = RST_VERSION;
			max_hdr_cfg = RST_MAX_HEADERS;
			clear_set();
		endfunction

		function void clear_set();
			seen      = '0;
			agreed    = '0;
			taken     = '0;
			zero_seen = 1'b0;
			latched   = 1'b0;
		endfunction

		function void fail(string msg);
			errors++;
			if (errors <= 10) $display("mismatch: %s", msg);
		endfunction

		function void write_reg(reg_idx_t r, logic [63:0] v);
			case (r)
				REG_SET_ID:      set_id_cfg  = v;
				REG_VERSION:     version_cfg = v[7:0];
				REG_MAX_HEADERS: max_hdr_cfg = v[10:0];
				default: ;
			endcase
		endfunction

		function void note_header(hdr_word_t h);
			bit good;
			bit ok;
			good = 1'b1;
			hdrs++;
			if (!latched) begin
				if (h.hdr_version != version_cfg) good = 1'b0;
				else if (h.hdr_shard_count == 8'd0 || h.hdr_shard_count > MAX_SHARDS) good = 1'b0;
				else if (h.hdr_shard_index >= h.hdr_shard_count) good = 1'b0;
				else if (h.hdr_set_id != set_id_cfg) good = 1'b0;
				else if (taken != 11'd0 && h.hdr_shard_count != agreed) good = 1'b0;
				else if (seen[h.hdr_shard_index[4:0]]) good = 1'b0;
				if (good) begin
					if (taken == 11'd0) agreed = h.hdr_shard_count;
					seen[h.hdr_shard_index[4:0]] = 1'b1;
					if (h.hdr_shard_index == 8'd0) zero_seen = 1'b1;
				end else begin
					latched = 1'b1;
				end
			end
			if (taken != HDRS_TAKEN_MAX) taken++;
			if (taken > max_hdr_cfg) latched = 1'b1;
			if (h.set_end) begin
				ok = !latched && zero_seen && taken == {3'd0, agreed};
				pending.push_back('{status: ok ? STATUS_OK : STATUS_BAD,
					total_shards: ok ? agreed : 8'd0});
				clear_set();
			end
		endfunction

		function void check_result(res_word_t r);
			res_word_t e;
			if (pending.size() == 0) begin
				fail($sformatf("status word %0d/%0d with none expected",
					r.status, r.total_shards));
				return;
			end
			e = pending.pop_front();
			if (e.status == STATUS_OK) sets_ok++;
			else sets_bad++;
			if (r.status !== e.status)
				fail($sformatf("status exp %0d got %0d", e.status, r.status));
			if (r.total_shards !== e.total_shards)
				fail($sformatf("total_shards exp %0d got %0d",
					e.total_shards, r.total_shards));
		endfunction
	endclass

	logic              clk;
	logic              arst_n;
	logic              psel;
	logic              penable;
	logic              pwrite;
	logic [ADDR_W-1:0] paddr;
	logic [DATA_W-1:0] pwdata;
	logic [DATA_W-1:0] prdata;
	logic              pready;
	logic              hdr_valid;
	logic              hdr_stall;
	hdr_word_t         hdr;
	logic              res_valid;
	logic              res_stall;
	res_word_t         res;

	shard_set_scoreboard sb = new();
	bit idle_en;
	bit hold_req;
	int words_sent;
	int cycles = 0;

	shard_set_validator_core u_top (
		.clk      (clk),
		.arst_n   (arst_n),
		.psel     (psel),
		.penable  (penable),
		.pwrite   (pwrite),
		.paddr    (paddr),
		.pwdata   (pwdata),
		.prdata   (prdata),
		.pready   (pready),
		.hdr_valid(hdr_valid),
		.hdr_stall(hdr_stall),
		.hdr      (hdr),
		.res_valid(res_valid),
		.res_stall(res_stall),
		.res      (res)
	);

	initial begin
		clk = 1'b0;
		forever #5 clk = ~clk;
	end

	always @(posedge clk) begin
		cycles <= cycles + 1;
		if (cycles > CYCLE_LIMIT) begin
			$display("simulation failed");
			$finish;
		end
	end

	// both handshakes sampled mid-cycle, where inputs and outputs are settled
	always @(negedge clk) begin
		if (arst_n) begin
			if (hdr_valid && !hdr_stall) sb.note_header(hdr);
			if (res_valid && !res_stall) sb.check_result(res);
		end
	end

	initial begin
		res_stall = 1'b0;
		@(posedge arst_n);
		forever begin
			@(posedge clk);
			if (hold_req) begin
				hold_req = 1'b0;
				res_stall <= 1'b1;
				repeat (300) @(posedge clk);
				res_stall <= 1'b0;
			end else if (idle_en && $urandom_range(0, 7) == 0) begin
				res_stall <= 1'b1;
				repeat ($urandom_range(1, 19)) @(posedge clk);
				res_stall <= 1'b0;
			end else begin
				res_stall <= 1'b0;
			end
		end
	end

	function automatic hdr_word_t mk(logic [7:0] ver, logic [7:0] cnt, logic [7:0] idx,
			logic [63:0] sid, logic fin);
		hdr_word_t w;
		w.hdr_version     = ver;
		w.hdr_shard_count = cnt;
		w.hdr_shard_index = idx;
		w.hdr_set_id      = sid;
		w.set_end         = fin;
		return w;
	endfunction

	task automatic send_hdr(input hdr_word_t w);
		bit taken;
		if (idle_en && $urandom_range(0, 7) == 0) begin
			hdr_valid <= 1'b0;
			repeat ($urandom_range(1, 19)) @(posedge clk);
		end
		hdr       <= w;
		hdr_valid <= 1'b1;
		do begin
			@(negedge clk);
			taken = !hdr_stall;
			@(posedge clk);
		end while (!taken);
		words_sent++;
	endtask

	task automatic wait_idle();
		hdr_valid <= 1'b0;
		while (sb.pending.size() != 0) @(posedge clk);
		repeat (6) @(posedge clk);
	endtask

	task automatic apb_xfer(input bit wr, input reg_idx_t r, input logic [63:0] wd,
			output logic [63:0] rd);
		bit rdy;
		psel    <= 1'b1;
		penable <= 1'b0;
		pwrite  <= wr;
		paddr   <= ADDR_W'(8 * int'(r));
		pwdata  <= wd;
		@(posedge clk);
		penable <= 1'b1;
		do begin
			@(negedge clk);
			rdy = pready;
			rd  = prdata;
			@(posedge clk);
		end while (!rdy);
		psel    <= 1'b0;
		penable <= 1'b0;
		pwrite  <= 1'b0;
		@(posedge clk);
	endtask

	task automatic write_cfg(input reg_idx_t r, input logic [63:0] v, input logic [63:0] mask);
		logic [63:0] rd;
		apb_xfer(1'b1, r, v, rd);
		sb.write_reg(r, v);
		apb_xfer(1'b0, r, '0, rd);
		if ((rd & mask) !== (v & mask))
			sb.fail($sformatf("register %s read %h, wrote %h", r.name(), rd & mask, v & mask));
	endtask

	task automatic program_phase(input int ph);
		logic [63:0] sid;
		logic [7:0]  ver;
		logic [10:0] mx;
		case (ph)
			0: begin
				sid = '0;
				ver = 8'd0;
				mx  = 11'd1024;
			end
			1: begin
				sid = '1;
				ver = 8'hff;
				mx  = 11'd1;
			end
			default: begin
				sid = {$urandom, $urandom};
				ver = 8'($urandom);
				mx  = ($urandom_range(0, 3) == 0) ? 11'($urandom_range(1, 1024))
					: 11'($urandom_range(1, 40));
			end
		endcase
		if (ph == 6) mx = 11'd1024;
		write_cfg(REG_SET_ID, sid, '1);
		write_cfg(REG_VERSION, {$urandom, 24'($urandom), ver}, 64'hff);
		write_cfg(REG_MAX_HEADERS, {$urandom, 21'($urandom), mx}, 64'h7ff);
	endtask

	function automatic hdr_word_t noise_word(bit end_ok);
		hdr_word_t w;
		w = hdr_word_t'(HDR_W'({$urandom, $urandom, $urandom}));
		if ($urandom_range(0, 1)) w.hdr_version = sb.version_cfg;
		if ($urandom_range(0, 1)) w.hdr_set_id = sb.set_id_cfg;
		if ($urandom_range(0, 1)) w.hdr_shard_count = 8'($urandom_range(0, MAX_SHARDS + 1));
		if ($urandom_range(0, 1)) w.hdr_shard_index = 8'($urandom_range(0, MAX_SHARDS));
		w.set_end = end_ok && $urandom_range(0, 15) == 0;
		return w;
	endfunction

	task automatic send_set(input set_kind_e kind);
		hdr_word_t q[$];
		int order[MAX_SHARDS];
		int n;
		int pos;
		int other;
		int t;
		n = ($urandom_range(0, 5) == 0) ? MAX_SHARDS : $urandom_range(1, MAX_SHARDS);
		if ((kind == SK_DUP || kind == SK_MISSING) && n < 2) n = 2;
		for (int i = 0; i < n; i++) order[i] = i;
		for (int i = n - 1; i > 0; i--) begin
			t = $urandom_range(0, i);
			other = order[i];
			order[i] = order[t];
			order[t] = other;
		end
		for (int i = 0; i < n; i++)
			q.push_back(mk(sb.version_cfg, 8'(n), 8'(order[i]), sb.set_id_cfg, 1'b0));
		pos = $urandom_range(0, n - 1);
		case (kind)
			SK_VERSION: q[pos].hdr_version = sb.version_cfg ^ 8'($urandom_range(1, 255));
			SK_COUNT: q[pos].hdr_shard_count = $urandom_range(0, 1) ? 8'd0
				: 8'($urandom_range(MAX_SHARDS + 1, 255));
			SK_INDEX: q[pos].hdr_shard_index = 8'($urandom_range(n, 255));
			SK_SET_ID: q[pos].hdr_set_id = sb.set_id_cfg ^ (64'd1 << $urandom_range(0, 63));
			SK_COUNT_CHANGE: q[pos].hdr_shard_count =
				8'(((n - 1 + $urandom_range(1, MAX_SHARDS - 1)) % MAX_SHARDS) + 1);
			SK_DUP: begin
				other = (pos + $urandom_range(1, n - 1)) % n;
				q[pos].hdr_shard_index = q[other].hdr_shard_index;
			end
			SK_MISSING: q.delete(pos);
			SK_NOISE: begin
				q.delete();
				repeat ($urandom_range(1, 40)) q.push_back(noise_word(1'b1));
			end
			default: ;
		endcase
		q[q.size() - 1].set_end = 1'b1;
		foreach (q[i]) send_hdr(q[i]);
	endtask

	function automatic set_kind_e pick_kind();
		int r;
		r = $urandom_range(0, 18);
		if (r < 11) return SK_GOOD;
		return set_kind_e'(r - 10);
	endfunction

	initial begin
		int start;
		int drain;
		arst_n    = 1'b0;
		psel      = 1'b0;
		penable   = 1'b0;
		pwrite    = 1'b0;
		paddr     = '0;
		pwdata    = '0;
		hdr_valid = 1'b0;
		hdr       = '0;
		idle_en   = 1'b0;
		hold_req  = 1'b0;
		repeat (9) @(posedge clk);
		arst_n <= 1'b1;
		@(posedge clk);

		// directed cases at reset settings, then with the header limit set to one
		send_hdr(mk(8'd2, 8'd1, 8'd0, 64'd0, 1'b1));
		send_hdr(mk(8'd2, 8'd2, 8'd1, 64'd0, 1'b0));
		send_hdr(mk(8'd2, 8'd2, 8'd0, 64'd0, 1'b1));
		send_hdr(mk(8'hff, 8'd1, 8'd0, 64'd0, 1'b1));
		send_hdr(mk(8'd0, 8'd1, 8'd0, 64'd0, 1'b1));
		send_hdr(mk(8'd2, 8'd0, 8'd0, 64'd0, 1'b1));
		send_hdr(mk(8'd2, 8'hff, 8'd0, 64'd0, 1'b1));
		send_hdr(mk(8'd2, 8'd33, 8'd0, 64'd0, 1'b1));
		send_hdr(mk(8'd2, 8'd1, 8'hff, 64'd0, 1'b1));
		send_hdr(mk(8'd2, 8'd1, 8'd0, '1, 1'b1));
		send_hdr(mk(8'd2, 8'd2, 8'd0, 64'd0, 1'b0));
		send_hdr(mk(8'd2, 8'd3, 8'd1, 64'd0, 1'b1));
		send_hdr(mk(8'd2, 8'd2, 8'd0, 64'd0, 1'b0));
		send_hdr(mk(8'd2, 8'd2, 8'd0, 64'd0, 1'b1));
		send_hdr(mk(8'd2, 8'd3, 8'd0, 64'd0, 1'b0));
		send_hdr(mk(8'd2, 8'd3, 8'd2, 64'd0, 1'b1));
		send_hdr(mk(8'd2, 8'd2, 8'd1, 64'd0, 1'b1));
		send_hdr(mk(8'd3, 8'd2, 8'd0, 64'd0, 1'b0));
		send_hdr(mk(8'd2, 8'd2, 8'd0, 64'd0, 1'b0));
		send_hdr(mk(8'd2, 8'd2, 8'd1, 64'd0, 1'b1));
		wait_idle();
		write_cfg(REG_MAX_HEADERS, 64'd1, 64'h7ff);
		send_hdr(mk(8'd2, 8'd2, 8'd0, 64'd0, 1'b0));
		send_hdr(mk(8'd2, 8'd2, 8'd1, 64'd0, 1'b1));
		send_hdr(mk(8'd2, 8'd1, 8'd0, 64'd0, 1'b1));

		for (int ph = 0; ph < N_PHASES; ph++) begin
			wait_idle();
			program_phase(ph);
			idle_en = (ph < N_PHASES - 2) && ph != 4 && ph != 6;
			if (ph == 3) hold_req = 1'b1;
			start = words_sent;
			while (words_sent - start < PHASE_WORDS) send_set(pick_kind());
		end

		hdr_valid <= 1'b0;
		idle_en = 1'b0;
		drain = 0;
		while (sb.pending.size() != 0 && drain < 5000) begin
			@(posedge clk);
			drain++;
		end
		repeat (10) @(posedge clk);
		if (sb.pending.size() != 0)
			sb.fail($sformatf("%0d status words never arrived", sb.pending.size()));
		$display("sent %0d header words over %0d register settings", sb.hdrs, N_PHASES + 2);
		$display("checked %0d good sets and %0d bad-format sets, %0d errors",
			sb.sets_ok, sb.sets_bad, sb.errors);
		if (sb.errors == 0) begin
			$display("simulation ok");
		end else begin
			$display("simulation failed");
		end
		$finish;
	end

endmodule
`default_nettype wire
